// File: rtl/wms_pkg.sv
`timescale 1ns / 1ps
package wms_pkg;

  localparam int MaxHalfDef    = 15;
  localparam int SampleBitsDef = 24;
  localparam int AddrBits      = 3;

  // Configuration register byte addresses.
  localparam logic [AddrBits-1:0] RegFilterMode = 3'd0;
  localparam logic [AddrBits-1:0] RegHalfWidth  = 3'd4;

  localparam logic ModeMean   = 1'b0;
  localparam logic ModeMedian = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SORT,
    ST_DIV,
    ST_EMIT
  } wms_state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic store;    // write the accepted sample into the ring
    logic start;    // set up the window of the next output
    logic load;     // fetch one window sample
    logic sort;     // one odd-even transposition sort step
    logic div_init; // prepare the divider
    logic div_step; // one restoring division step
    logic emit;     // load the output register
    logic clear;    // end of row
  } wms_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic load_done;
    logic sort_done;
    logic div_done;
    logic need_div;
    logic pending;  // another output is due for this beat
    logic is_last;  // the accepted beat closes the row
  } wms_sts_t;

endpackage

// File: rtl/wms_if.sv
`timescale 1ns / 1ps
interface wms_if #(
  parameter int W = 24
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  logic         last;

  modport source (output valid, output data, output last, input ready);
  modport sink (input valid, input data, input last, output ready);
endinterface

// File: rtl/wms_ctrl.sv
`timescale 1ns / 1ps
module wms_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_busy,
  input  wms_pkg::wms_sts_t sts,
  output wms_pkg::wms_cmd_t cmd
);
  import wms_pkg::*;

  wms_state_t state_r, state_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!sts.pending) begin
          state_nxt = ST_IDLE;
        end else if (sts.load_done) begin
          state_nxt = ST_SORT;
        end
      end
      ST_SORT: begin
        if (sts.sort_done) begin
          state_nxt = sts.need_div ? ST_DIV : ST_EMIT;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_busy) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.store = in_valid;
      end
      ST_LOAD: begin
        cmd.load = sts.pending;
        cmd.clear = !sts.pending && sts.is_last;
      end
      ST_SORT: begin
        cmd.sort     = 1'b1;
        cmd.div_init = sts.sort_done;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = !out_busy;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // An item is taken only while idle.
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == ST_IDLE)
    else $error("ready outside idle");
  // Emission follows sorting or division.
  a_emit_path: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT && $past(state_r) != ST_EMIT |->
      $past(state_r) == ST_SORT || $past(state_r) == ST_DIV)
    else $error("emit without compute");
  // No emit command while the output holds a beat.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !out_busy)
    else $error("emit overwrites output");
endmodule

// File: rtl/wms_dp.sv
`timescale 1ns / 1ps
module wms_dp #(
  parameter int MAX_HALF    = wms_pkg::MaxHalfDef,
  parameter int SAMPLE_BITS = wms_pkg::SampleBitsDef
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  wms_pkg::wms_cmd_t      cmd,
  output wms_pkg::wms_sts_t      sts,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   in_last,
  input  logic                   mode,
  input  logic [3:0]             half_width,
  output logic [SAMPLE_BITS-1:0] res_value,
  output logic                   res_last
);
  import wms_pkg::*;

  localparam int Depth = 2 * MAX_HALF + 1;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);
  localparam int SumW  = SAMPLE_BITS + CntW + 1;
  localparam int HW    = $clog2(MAX_HALF + 1) + 1;

  // Sample ring, one write port and one read port.
  logic signed [SAMPLE_BITS-1:0] ring [Depth];
  logic [PtrW-1:0]  wr_ptr_r;
  logic [15:0]      recv_r, emit_r;
  logic             last_seen_r;
  logic             cnt_done_r;  // the one mid-row output of this beat is done
  logic [HW-1:0]    diff_r;  // distance of the next output behind the newest sample
  logic [HW-1:0]    h_eff;
  logic [HW:0]      hw_ext;

  // Window build.
  logic [CntW-1:0]  cnt_r, ld_idx_r, ld_got_r;
  logic [PtrW-1:0]  rd_ptr_r;
  logic signed [SAMPLE_BITS-1:0] rd_data_r;
  logic             rd_vld_r;  // rd_ptr_r holds an address of the window
  logic             rd_dv_r;   // rd_data_r holds a window sample
  logic             cap_w;
  logic signed [SAMPLE_BITS-1:0] win_r [Depth];
  logic signed [SumW-1:0] sum_r;
  logic             last_out_r;
  logic [CntW-1:0]  sort_pass_r;
  logic             sort_swapped_r, sort_phase_r;

  // Divider.
  logic [SumW-1:0]  dnum_r, drem_r;
  logic [CntW-1:0]  dden_r;
  logic [$clog2(SumW+1)-1:0] dstep_r;
  logic             dneg_r;
  logic signed [SAMPLE_BITS-1:0] result_w;

  assign hw_ext = HW'(half_width) > HW'(MAX_HALF) ? (HW+1)'(MAX_HALF)
                                                  : (HW+1)'(half_width);
  assign h_eff  = hw_ext[HW-1:0];

  // Output due: in a row, when backlog reached h; after the last sample, all.
  logic pending;
  assign pending = last_seen_r ? (diff_r != '1) : (diff_r >= h_eff && !cnt_done_r);

  // Window edges of the next output.
  logic [HW-1:0] right_w, left_w;
  logic [CntW-1:0] cnt_w;
  assign right_w = diff_r < h_eff ? diff_r : h_eff;
  assign left_w  = emit_r < 16'(h_eff) ? emit_r[HW-1:0] : h_eff;
  assign cnt_w   = CntW'(right_w) + CntW'(left_w) + CntW'(1);

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      ring[wr_ptr_r] <= in_sample;
    end
    rd_data_r <= ring[rd_ptr_r];
  end

  // Row bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      wr_ptr_r    <= '0;
      recv_r      <= '0;
      emit_r      <= '0;
      diff_r      <= '0;
      last_seen_r <= 1'b0;
      cnt_done_r  <= 1'b0;
    end else begin
      if (cmd.store) begin
        wr_ptr_r    <= wr_ptr_r == PtrW'(Depth - 1) ? '0 : wr_ptr_r + 1'b1;
        recv_r      <= recv_r + 1'b1;
        last_seen_r <= in_last;
        cnt_done_r  <= 1'b0;
        // backlog r - emitted, capped at MAX_HALF
        diff_r <= (recv_r - emit_r) > 16'(MAX_HALF) ? HW'(MAX_HALF)
                                                    : HW'(recv_r - emit_r);
      end
      if (cmd.emit) begin
        emit_r <= emit_r + 1'b1;
        if (last_seen_r) begin
          diff_r <= diff_r - 1'b1;
        end else begin
          cnt_done_r <= 1'b1;
        end
      end
    end
  end

  // Window fetch: oldest sample first, one per cycle.
  logic [PtrW-1:0] start_ptr;
  logic [PtrW:0]   back;
  always_comb begin
    back = (PtrW+1)'(diff_r) + (PtrW+1)'(left_w) + 1'b1;
    start_ptr = (PtrW+1)'(wr_ptr_r) >= back ? PtrW'((PtrW+1)'(wr_ptr_r) - back)
                : PtrW'((PtrW+1)'(wr_ptr_r) + (PtrW+1)'(Depth) - back);
  end

  // A ring word arrives in the cycle after its address.
  assign cap_w = cmd.load && rd_dv_r && ld_got_r < cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      rd_dv_r  <= 1'b0;
      ld_idx_r <= '0;
      ld_got_r <= '0;
    end else if (cmd.load) begin
      rd_dv_r <= rd_vld_r;
      if (ld_idx_r == '0 && ld_got_r == '0 && !rd_vld_r) begin
        rd_ptr_r   <= start_ptr;
        cnt_r      <= cnt_w;
        sum_r      <= '0;
        last_out_r <= last_seen_r && diff_r == '0;
        ld_idx_r   <= CntW'(1);
        rd_vld_r   <= 1'b1;
      end else begin
        rd_ptr_r <= rd_ptr_r == PtrW'(Depth - 1) ? '0 : rd_ptr_r + 1'b1;
        ld_idx_r <= ld_idx_r + 1'b1;
        rd_vld_r <= ld_idx_r < cnt_r;
        if (cap_w) begin
          sum_r    <= sum_r + SumW'(rd_data_r);
          ld_got_r <= ld_got_r + 1'b1;
        end
      end
    end else begin
      rd_vld_r <= 1'b0;
      rd_dv_r  <= 1'b0;
      ld_idx_r <= '0;
      ld_got_r <= '0;
    end
  end

  // Window registers: filled by the fetch, then sorted in place.
  always_ff @(posedge clk) begin
    if (cap_w) begin
      win_r[ld_got_r[PtrW-1:0]] <= rd_data_r;
    end else if (cmd.sort) begin
      for (int k = 0; k + 1 < Depth; k++) begin
        if ((k % 2) == int'(sort_phase_r) && CntW'(k + 1) < cnt_r
            && win_r[k] > win_r[k+1]) begin
          win_r[k]   <= win_r[k+1];
          win_r[k+1] <= win_r[k];
        end
      end
    end
  end

  // Odd-even transposition sort: one compare-exchange layer per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n || !cmd.sort) begin
      sort_pass_r    <= '0;
      sort_phase_r   <= 1'b0;
      sort_swapped_r <= 1'b0;
    end else begin
      sort_phase_r <= !sort_phase_r;
      sort_pass_r  <= sort_pass_r + 1'b1;
    end
  end

  // Middle entries of the sorted window; equal for an odd count.
  logic [CntW-1:0] mid_hi, mid_lo;
  assign mid_hi = cnt_r >> 1;
  assign mid_lo = (cnt_r - CntW'(1)) >> 1;

  // Even-count median: the two middle values averaged, ties away from zero.
  logic signed [SAMPLE_BITS:0] pair_sum;
  logic [SAMPLE_BITS:0]        pair_mag;
  logic [SAMPLE_BITS-1:0]      pair_avg;
  assign pair_sum = (SAMPLE_BITS+1)'(win_r[mid_hi[PtrW-1:0]])
                  + (SAMPLE_BITS+1)'(win_r[mid_lo[PtrW-1:0]]);
  assign pair_mag = pair_sum[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-pair_sum) : pair_sum;
  assign pair_avg = SAMPLE_BITS'((pair_mag + (SAMPLE_BITS+1)'(1)) >> 1);

  // Divider for the mean: numerator is |sum| + cnt/2 over cnt.
  logic [SumW:0] trial;
  assign trial = {drem_r, dnum_r[SumW-1]} - (SumW+1)'(dden_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dstep_r <= '0;
    end else if (cmd.div_init) begin
      dneg_r  <= sum_r[SumW-1];
      dnum_r  <= (sum_r[SumW-1] ? -sum_r : sum_r) + SumW'(cnt_r >> 1);
      dden_r  <= cnt_r;
      drem_r  <= '0;
      dstep_r <= '0;
    end else if (cmd.div_step) begin
      if (!trial[SumW]) begin
        drem_r <= trial[SumW-1:0];
        dnum_r <= {dnum_r[SumW-2:0], 1'b1};
      end else begin
        drem_r <= {drem_r[SumW-2:0], dnum_r[SumW-1]};
        dnum_r <= {dnum_r[SumW-2:0], 1'b0};
      end
      dstep_r <= dstep_r + 1'b1;
    end
  end

  always_comb begin
    if (mode == ModeMean) begin
      result_w = dneg_r ? -SAMPLE_BITS'(dnum_r) : SAMPLE_BITS'(dnum_r);
    end else if (cnt_r[0]) begin
      result_w = win_r[mid_hi[PtrW-1:0]];
    end else begin
      result_w = pair_sum[SAMPLE_BITS] ? -pair_avg : pair_avg;
    end
  end

  assign res_value = result_w;
  assign res_last  = last_out_r;

  always_comb begin
    sts.pending   = pending;
    sts.load_done = ld_got_r == cnt_r && ld_got_r != '0;
    sts.sort_done = mode == ModeMean || sort_pass_r >= cnt_r;
    sts.need_div  = mode == ModeMean;
    sts.div_done  = dstep_r == ($clog2(SumW+1))'(SumW - 1);
    sts.is_last   = last_seen_r;
  end

  // The window never exceeds the ring.
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sort |-> cnt_r <= CntW'(Depth) && cnt_r != '0)
    else $error("window count out of range");
  // Backlog never exceeds the cap.
  a_diff_cap: assert property (@(posedge clk) disable iff (!rst_n)
    !last_seen_r |-> diff_r <= HW'(MAX_HALF))
    else $error("backlog overflow");
  // A store clears the per-beat mark.
  a_store: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |=> !cnt_done_r)
    else $error("stale output mark");
endmodule

// File: rtl/window_mean_median_smoother.sv
`timescale 1ns / 1ps
// Flow: for an output with a window of n = up to 2h+1 samples, the window is fetched, then
// sorted for a median, or the divider is prepared and runs SumW (30) divide steps for a mean;
// the result is then loaded into the output register once that register is free.
// The block takes one sample at a time: it accepts a new sample only while idle, once
// every output due for the previous sample has been emitted.
// Reset (rst_n low, synchronous) clears the row counters, the state machine,
// the output valid flag and the registers (filter_mode 0, half_width 4).
module window_mean_median_smoother #(
  parameter int MAX_HALF    = wms_pkg::MaxHalfDef,
  parameter int SAMPLE_BITS = wms_pkg::SampleBitsDef
) (
  input  logic                      clk,
  input  logic                      rst_n,
  wms_if.sink                       in_ch,
  wms_if.source                     out_ch,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [wms_pkg::AddrBits-1:0] cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);
  import wms_pkg::*;

  wms_cmd_t cmd;
  wms_sts_t sts;
  logic mode_r;
  logic [3:0] hw_r;
  logic [SAMPLE_BITS-1:0] res_value;
  logic res_last;
  logic out_vld_r;
  logic [SAMPLE_BITS-1:0] out_data_r;
  logic out_last_r;

  // Register file.
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ModeMean;
      hw_r   <= 4'd4;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr)
        RegFilterMode: mode_r <= cfg_pwdata[0];
        RegHalfWidth:  hw_r   <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr)
      RegFilterMode: cfg_prdata = {31'd0, mode_r};
      RegHalfWidth:  cfg_prdata = {28'd0, hw_r};
      default:       cfg_prdata = '0;
    endcase
  end

  wms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_busy (out_vld_r && !out_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wms_dp #(
    .MAX_HALF    (MAX_HALF),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_sample  (in_ch.data),
    .in_last    (in_ch.last),
    .mode       (mode_r),
    .half_width (hw_r),
    .res_value  (res_value),
    .res_last   (res_last)
  );

  // Output register holds one beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.emit) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
    if (cmd.emit) begin
      out_data_r <= res_value;
      out_last_r <= res_last;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_data_r;
  assign out_ch.last  = out_last_r;
endmodule

// File: test/window_mean_median_smoother_tb.sv
`timescale 1ns / 1ps
module window_mean_median_smoother_tb;
  import wms_pkg::*;

  localparam int Depth = 2 * MaxHalfDef + 1;

  // Predicts smoothed values and holds them until the block emits them.
  class smooth_board;
    logic signed [23:0] ring[Depth];
    int unsigned wr_ptr, rcv_cnt, emit_cnt;
    logic mode;
    int unsigned hw;
    logic [23:0] exp_val[$];
    logic exp_last[$];
    int errors;

    function new();
      wr_ptr = 0; rcv_cnt = 0; emit_cnt = 0; mode = ModeMean; hw = 4; errors = 0;
      foreach (ring[k]) ring[k] = '0;
    endfunction

    function longint rdiv(longint num, longint n);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (mag + n / 2) / n;
      return (num < 0) ? -q : q;
    endfunction

    function longint window_value(int unsigned di, int unsigned idx, int unsigned h);
      longint buf_v[Depth];
      longint v, sum;
      int unsigned right, left, cnt, j;
      right = (di < h) ? di : h;
      left = (idx < h) ? idx : h;
      cnt = right + left + 1;
      if (cnt > Depth) cnt = Depth;
      for (int k = 0; k < cnt; k++)
        buf_v[k] = ring[(wr_ptr + Depth - 1 - ((di - right + k) % Depth)) % Depth];
      if (mode == ModeMean) begin
        sum = 0;
        for (int k = 0; k < cnt; k++) sum += buf_v[k];
        return rdiv(sum, cnt);
      end
      for (int k = 1; k < cnt; k++) begin
        v = buf_v[k];
        j = k;
        while (j > 0 && buf_v[j-1] > v) begin
          buf_v[j] = buf_v[j-1];
          j--;
        end
        buf_v[j] = v;
      end
      if (cnt & 1) return buf_v[cnt/2];
      return rdiv(buf_v[cnt/2-1] + buf_v[cnt/2], 2);
    endfunction

    function void note_sample(logic [23:0] s, logic lst);
      int unsigned h, r, diff, idx, di;
      longint v;
      h = (hw > MaxHalfDef) ? MaxHalfDef : hw;
      r = rcv_cnt;
      ring[wr_ptr % Depth] = s;
      wr_ptr = (wr_ptr + 1) % Depth;
      rcv_cnt = (rcv_cnt + 1) & 16'hFFFF;
      diff = (r - emit_cnt) & 16'hFFFF;
      if (diff > MaxHalfDef) diff = MaxHalfDef;
      if (!lst) begin
        if (diff >= h) begin
          v = window_value(diff, emit_cnt, h);
          exp_val.push_back(v[23:0]);
          exp_last.push_back(1'b0);
          emit_cnt = (emit_cnt + 1) & 16'hFFFF;
        end
      end else begin
        for (int unsigned n = 0; n <= diff; n++) begin
          idx = (emit_cnt + n) & 16'hFFFF;
          di = diff - n;
          v = window_value(di, idx, h);
          exp_val.push_back(v[23:0]);
          exp_last.push_back(di == 0);
        end
        rcv_cnt = 0; emit_cnt = 0; wr_ptr = 0;
      end
    endfunction

    function void check_result(logic [23:0] val, logic lst);
      logic [23:0] ev;
      logic el;
      if (exp_val.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat: value %h last %b", val, lst);
        return;
      end
      ev = exp_val.pop_front();
      el = exp_last.pop_front();
      if (ev !== val || el !== lst) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected %h/%b, got %h/%b", ev, el, val, lst);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [AddrBits-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  wms_if #(.W(24)) in_ch ();
  wms_if #(.W(24)) out_ch ();

  window_mean_median_smoother dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  smooth_board board = new();
  int cycles = 0;
  bit hold_long = 1'b0;
  bit drain_done = 1'b0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
  end

  // Clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > 1500000) begin
      $display("window_mean_median_smoother regression: fail");
      $finish;
    end
  end

  // Result checking at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_result(out_ch.data, out_ch.last);
  end

  // Receiver with random stalls, and a long hold-off when asked.
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_long = 1'b0;
      end
      g = $urandom_range(0, 99);
      if (drain_done || g < 60) out_ch.ready <= 1'b1;
      else if (g < 95) out_ch.ready <= 1'b0;
      else begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(20, 80)) @(negedge clk);
      end
    end
  end

  task automatic cfg_write(logic [AddrBits-1:0] addr, logic [31:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= addr; cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (addr == RegFilterMode) board.mode = value[0];
    else if (addr == RegHalfWidth) board.hw = value[3:0];
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  // Sends one sample beat; idles before it at random.
  task automatic send_sample(logic [23:0] s, logic lst, bit allow_gap);
    int g;
    if (allow_gap) begin
      g = $urandom_range(0, 99);
      if (g >= 70) begin
        in_ch.valid <= 1'b0;
        repeat ((g >= 97) ? $urandom_range(30, 120) : $urandom_range(1, 4))
          @(negedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= s;
    in_ch.last <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_sample(s, lst);
    @(negedge clk);
  endtask

  task automatic go_idle();
    in_ch.valid <= 1'b0;
    while (board.exp_val.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  function automatic logic [23:0] rand_sample();
    int c;
    c = $urandom_range(0, 9);
    if (c == 0) return 24'h7FFFFF;
    if (c == 1) return 24'h800000;
    if (c < 5) return $urandom_range(0, 2047) - 1024;
    return $urandom();
  endfunction

  // Sends a row of random samples.
  task automatic send_row(int len);
    for (int k = 0; k < len; k++)
      send_sample(rand_sample(), k == len - 1, 1'b1);
  endtask

  initial begin
    int sent, len;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: default settings, extremes, short rows.
    send_sample(24'h7FFFFF, 1'b0, 1'b0);
    send_sample(24'h7FFFFF, 1'b0, 1'b0);
    send_sample(24'h800000, 1'b0, 1'b0);
    send_sample(24'h800000, 1'b0, 1'b0);
    send_sample(24'h000000, 1'b0, 1'b0);
    send_sample(24'hFFFFFF, 1'b0, 1'b0);
    send_sample(24'h000001, 1'b1, 1'b0);
    // A single-sample row.
    send_sample(24'h123456, 1'b1, 1'b0);
    go_idle();
    cfg_write(RegFilterMode, {31'd0, ModeMedian});
    // Medians over a three-sample row with negative values.
    send_sample(24'hFFFFFF, 1'b0, 1'b0);
    send_sample(24'hFFFFFE, 1'b0, 1'b0);
    send_sample(24'h000003, 1'b1, 1'b0);
    go_idle();
    // Pass-through with half width zero.
    cfg_write(RegHalfWidth, 32'd0);
    send_sample(24'h7FFFFF, 1'b0, 1'b0);
    send_sample(24'h800000, 1'b1, 1'b0);
    go_idle();
    // Widest window with a row shorter than it.
    cfg_write(RegHalfWidth, 32'd15);
    send_row(6);
    go_idle();
    sent = 19;

    // Random phases through several settings; a long receiver hold-off in one.
    for (int ph = 0; sent < 150; ph++) begin
      cfg_write(RegFilterMode, {31'd0, ph[0]});
      case (ph % 5)
        0: cfg_write(RegHalfWidth, 32'd1);
        1: cfg_write(RegHalfWidth, 32'd15);
        2: cfg_write(RegHalfWidth, 32'd0);
        default: cfg_write(RegHalfWidth, $urandom_range(1, 15));
      endcase
      if (ph == 1) hold_long = 1'b1;
      for (int r = 0; r < 3; r++) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40);
        send_row(len);
        sent += len;
      end
      go_idle();
    end

    drain_done = 1'b1;
    while (board.exp_val.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (board.errors == 0 && board.exp_val.size() == 0)
      $display("window_mean_median_smoother regression: pass");
    else
      $display("window_mean_median_smoother regression: fail");
    $finish;
  end
endmodule
